// ----- rtl/core/u8u16_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder core.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [CodeW-1:0] SurrHighBase = 21'h00D800;
  localparam logic [CodeW-1:0] SurrLowBase  = 21'h00DC00;
  localparam logic [CodeW-1:0] SuppBase     = 21'h010000;
  localparam logic [CodeW-1:0] CodeMax      = 21'h10FFFF;
  localparam logic [CodeW-1:0] BmpMax       = 21'h00FFFF;
  localparam logic [CodeW-1:0] SurrFirst    = 21'h00D800;
  localparam logic [CodeW-1:0] SurrLast     = 21'h00DFFF;
  localparam logic [CodeW-1:0] Min2Byte     = 21'h000080;
  localparam logic [CodeW-1:0] Min3Byte     = 21'h000800;
  localparam logic [CodeW-1:0] Min4Byte     = 21'h010000;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // One decoded event: a code point, or the error result of a string.
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             err;
    logic             fin;
  } cp_entry_t;

  function automatic logic code_point_ok(logic [CodeW-1:0] v, logic [2:0] len);
    logic ok;
    begin
      ok = 1'b1;
      if ((len == SeqLen2) && (v < Min2Byte)) ok = 1'b0;
      if ((len == SeqLen3) && (v < Min3Byte)) ok = 1'b0;
      if ((len == SeqLen4) && (v < Min4Byte)) ok = 1'b0;
      if (v > CodeMax) ok = 1'b0;
      if ((v >= SurrFirst) && (v <= SurrLast)) ok = 1'b0;
      code_point_ok = ok;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/utf8_to_utf16_transcoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Validating UTF-8 decoder emitting UTF-16 units or whole code points.
//
// Input channel (in_valid_i/in_ready_o) takes one byte per transfer, with
// end_of_string_i on the last byte of a string. Output channel
// (out_valid_o/out_ready_i) gives one unit per transfer; last_o marks the
// final unit of a string and is_error_o a rejected string (code_unit_o = 0).
// The config channel writes wide_output_mode; it is always ready. The user must
// write it only while the core is idle; the core itself does not enforce this.
// The first unit of a byte is registered in the event queue and then in the
// output register. The core takes one byte and gives one unit per cycle while
// the queue is not full and the receiver is ready; a surrogate pair occupies
// the emitter for both its units, with the event queue (FifoDepth entries)
// absorbing the difference. in_ready_o drops only when the queue is full.
// When the receiver stalls, the output register holds and the queue fills,
// then intake stops. Reset clears the string state, the queue and the mode.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core
  import u8u16_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_wide_output_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [CodeW-1:0] code_unit_o,
  output logic             is_error_o,
  output logic             last_o
);

  logic      wide_mode_q;
  logic      q_full, q_push, q_pop, q_valid;
  cp_entry_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      wide_mode_q <= cfg_wide_output_mode_i;
    end
  end

  u8u16_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  u8u16_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wide_mode_i (wide_mode_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_unit_o (code_unit_o),
    .is_error_o  (is_error_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/u8u16_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front
// Byte intake: gathers UTF-8 sequences, validates them and pushes code point
// or error events into the queue.
// ----------------------------------------------------------------------------
module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic      end_of_string_i,
  input  wire logic      q_full_i,
  output logic           q_push_o,
  output cp_entry_t      q_entry_o
);

  logic [1:0]       rem_q, rem_d;
  logic [CodeW-1:0] pv_q, pv_d;
  logic [2:0]       len_q, len_d;
  logic             err_q, err_d;

  logic             accept;
  logic             have_cp;
  logic [CodeW-1:0] cp;
  logic [CodeW-1:0] pv_next;
  logic [1:0]       rem_next;
  logic             err_now;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    rem_d    = rem_q;
    pv_d     = pv_q;
    len_d    = len_q;
    err_d    = err_q;
    have_cp  = 1'b0;
    cp       = '0;
    pv_next  = {pv_q[CodeW-7:0], data_byte_i[5:0]};
    rem_next = rem_q - 2'd1;
    if (!err_q) begin
      if (rem_q == 2'd0) begin
        if (data_byte_i[7] == 1'b0) begin
          cp      = {13'd0, data_byte_i};
          have_cp = 1'b1;
        end else if (data_byte_i[7:5] == 3'b110) begin
          if (data_byte_i[4:0] == 5'd0) begin
            err_d = 1'b1;
          end else begin
            pv_d  = {16'd0, data_byte_i[4:0]};
            len_d = SeqLen2;
            rem_d = 2'd1;
          end
        end else if (data_byte_i[7:4] == 4'b1110) begin
          pv_d  = {17'd0, data_byte_i[3:0]};
          len_d = SeqLen3;
          rem_d = 2'd2;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          pv_d  = {18'd0, data_byte_i[2:0]};
          len_d = SeqLen4;
          rem_d = 2'd3;
        end else begin
          err_d = 1'b1;
        end
      end else begin
        if (data_byte_i[7:6] != 2'b10) begin
          err_d = 1'b1;
        end else begin
          pv_d  = pv_next;
          rem_d = rem_next;
          if (rem_next == 2'd0) begin
            if (code_point_ok(pv_next, len_q)) begin
              cp      = pv_next;
              have_cp = 1'b1;
            end else begin
              err_d = 1'b1;
            end
            pv_d  = '0;
            len_d = '0;
          end
        end
      end
      if (end_of_string_i && !err_d && (rem_d != 2'd0)) begin
        err_d = 1'b1;
      end
    end
    err_now = err_d;
    if (end_of_string_i) begin
      rem_d = '0;
      pv_d  = '0;
      len_d = '0;
      err_d = 1'b0;
    end
  end

  assign q_push_o        = accept & (err_now ? end_of_string_i : have_cp);
  assign q_entry_o.code  = err_now ? '0 : cp;
  assign q_entry_o.err   = err_now;
  assign q_entry_o.fin   = end_of_string_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pv_q  <= '0;
      len_q <= '0;
      err_q <= 1'b0;
    end else if (accept) begin
      rem_q <= rem_d;
      pv_q  <= pv_d;
      len_q <= len_d;
      err_q <= err_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/u8u16_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_fifo
// Short event queue between the byte intake and the unit emitter.
// ----------------------------------------------------------------------------
module u8u16_fifo
  import u8u16_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  cp_entry_t      entry_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output cp_entry_t      entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cp_entry_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/u8u16_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back
// Unit emitter: turns queued events into UTF-16 units, surrogate pairs or
// whole code points, through a registered output stage.
// ----------------------------------------------------------------------------
module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wide_mode_i,
  input  wire logic        q_valid_i,
  input  cp_entry_t        q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [CodeW-1:0] code_unit_o,
  output logic             is_error_o,
  output logic             last_o
);

  logic             out_valid_q;
  logic [CodeW-1:0] code_q;
  logic             err_q, last_q;
  logic             pend_q;
  logic [CodeW-1:0] pend_code_q;
  logic             pend_fin_q;

  logic             load;
  logic             single;
  logic [CodeW-1:0] off;
  logic [CodeW-1:0] hi_unit, lo_unit;

  assign load    = ~out_valid_q | out_ready_i;
  assign q_pop_o = load & ~pend_q & q_valid_i;
  assign single  = q_entry_i.err | wide_mode_i | (q_entry_i.code <= BmpMax);
  assign off     = q_entry_i.code - SuppBase;
  assign hi_unit = SurrHighBase + {11'd0, off[19:10]};
  assign lo_unit = SurrLowBase + {11'd0, off[9:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= ~single;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        code_q <= pend_code_q;
        err_q  <= 1'b0;
        last_q <= pend_fin_q;
      end else if (q_valid_i) begin
        if (single) begin
          code_q <= q_entry_i.code;
          err_q  <= q_entry_i.err;
          last_q <= q_entry_i.fin;
        end else begin
          code_q      <= hi_unit;
          err_q       <= 1'b0;
          last_q      <= 1'b0;
          pend_code_q <= lo_unit;
          pend_fin_q  <= q_entry_i.fin;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_unit_o = code_q;
  assign is_error_o  = err_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire
